@@ rtl/cfd_pkg.sv @@
// Shared types and constants for the COBS frame decoder.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps
`default_nettype none
package cfd_pkg;

	localparam int MAX_FRAME_DEF = 256;
	localparam int HDR_LEN = 3;
	localparam int BYTE_W = 8;
	localparam int TDATA_W = 40;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_count;
		logic              bad_frame;
		logic              is_end;
		logic [BYTE_W-1:0] byte_index;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] frame_tag;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/cfd_step.sv @@
// Frame state registers and per-byte decode: COBS unstuffing, header capture,
// payload emission and end-of-frame status. Depends on cfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cfd_step #(
	parameter int MAX_FRAME = cfd_pkg::MAX_FRAME_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire logic [cfd_pkg::BYTE_W-1:0]   enc_byte,
	output logic                              has_result,
	output cfd_pkg::res_t                     result
);

	localparam int PW = $clog2(MAX_FRAME + 1);
	localparam int NW = $clog2(MAX_FRAME + 256);
	localparam int BW = cfd_pkg::BYTE_W;

	logic [PW-1:0] position_q, position_d;
	logic [NW-1:0] next_code_q, next_code_d;
	logic [BW-1:0] tag_q, tag_d;
	logic [BW-1:0] len_q, len_d;
	logic [BW-1:0] hsum_q, hsum_d;
	logic [BW-1:0] sum_q, sum_d;
	logic [BW-1:0] count_q, count_d;
	logic [BW-1:0] dec;
	logic          clear;

	always_comb begin
		position_d = position_q;
		next_code_d = next_code_q;
		tag_d = tag_q;
		len_d = len_q;
		hsum_d = hsum_q;
		sum_d = sum_q;
		count_d = count_q;
		clear = 1'b0;
		has_result = 1'b0;
		dec = enc_byte;
		result.frame_tag = tag_q;
		result.data_byte = '0;
		result.byte_index = '0;
		result.is_end = 1'b0;
		result.bad_frame = 1'b0;
		result.payload_count = '0;
		if (enc_byte == '0) begin
			clear = 1'b1;
			if (position_q > PW'(1)) begin
				has_result = 1'b1;
				result.is_end = 1'b1;
				result.payload_count = count_q;
				if (position_q < PW'(1 + cfd_pkg::HDR_LEN)) begin
					result.bad_frame = 1'b1;
				end else begin
					result.bad_frame = (count_q != len_q) || (sum_q != hsum_q);
				end
			end
		end else if (position_q >= PW'(MAX_FRAME)) begin
			// overlong frame: drop until delimiter
		end else if (position_q == '0) begin
			next_code_d = NW'(enc_byte);
			position_d = PW'(1);
		end else begin
			if (NW'(position_q) == next_code_q) begin
				dec = '0;
				next_code_d = next_code_q + NW'(enc_byte);
			end
			position_d = position_q + PW'(1);
			if (position_q == PW'(1)) begin
				tag_d = dec;
			end else if (position_q == PW'(2)) begin
				len_d = dec;
			end else if (position_q == PW'(3)) begin
				hsum_d = dec;
			end else if (count_q < len_q) begin
				has_result = 1'b1;
				result.data_byte = dec;
				result.byte_index = count_q;
				sum_d = sum_q + dec;
				count_d = count_q + BW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			next_code_q <= '0;
			tag_q <= '0;
			len_q <= '0;
			hsum_q <= '0;
			sum_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (clear) begin
				position_q <= '0;
				next_code_q <= '0;
				tag_q <= '0;
				len_q <= '0;
				hsum_q <= '0;
				sum_q <= '0;
				count_q <= '0;
			end else begin
				position_q <= position_d;
				next_code_q <= next_code_d;
				tag_q <= tag_d;
				len_q <= len_d;
				hsum_q <= hsum_d;
				sum_q <= sum_d;
				count_q <= count_d;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/cfd_skid.sv @@
// Output register with skid stage; ready toward the decoder is registered.
// Depends on cfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cfd_skid (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire cfd_pkg::res_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output cfd_pkg::res_t      out_data
);

	logic          out_valid_q;
	logic          skid_valid_q;
	cfd_pkg::res_t out_data_q;
	cfd_pkg::res_t skid_data_q;
	logic          in_fire;

	assign in_ready = !skid_valid_q;
	assign in_fire = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			out_valid_q <= skid_valid_q || in_fire;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_fire) begin
			skid_data_q <= in_data;
		end
	end

endmodule
`default_nettype wire

@@ rtl/cobs_frame_decoder_core.sv @@
// COBS frame decoder, top level. The result of an accepted byte is held in
// the cfd_skid output or skid register. Throughput: one byte per cycle;
// s_tready is registered from the skid stage and drops only while two
// results wait. Reset (arst_n low, asynchronous) clears frame state and
// empties the output stages. Uses cfd_pkg, cfd_step and cfd_skid.
`timescale 1ns / 1ps
`default_nettype none
module cobs_frame_decoder_core #(
	parameter int MAX_FRAME = cfd_pkg::MAX_FRAME_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,  // enc_byte
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// frame_tag, data_byte, byte_index, bad_frame, payload_count, zero pad
	output logic [cfd_pkg::TDATA_W-1:0]        m_tdata,
	output logic                               m_tlast   // is_end
);

	logic          accept;
	logic          step_has;
	cfd_pkg::res_t step_res;
	cfd_pkg::res_t out_res;

	assign accept = s_tvalid && s_tready;

	cfd_step #(
		.MAX_FRAME(MAX_FRAME)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.enc_byte(s_tdata),
		.has_result(step_has),
		.result(step_res)
	);

	cfd_skid u_skid (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(accept && step_has),
		.in_ready(s_tready),
		.in_data(step_res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(out_res)
	);

	assign m_tdata = {7'b0, out_res.payload_count, out_res.bad_frame, out_res.byte_index,
		out_res.data_byte, out_res.frame_tag};
	assign m_tlast = out_res.is_end;

`ifndef SYNTHESIS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("skid stage full while output empty");
	a_end_on_delim: assert property (@(posedge clk) disable iff (!arst_n)
		accept && step_has && step_res.is_end |-> s_tdata == 8'h00)
		else $error("end item without delimiter");
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		accept && step_has && !step_res.is_end |->
		!step_res.bad_frame && step_res.payload_count == 8'h00)
		else $error("payload item carries status fields");
	a_no_result_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tdata == 8'h00 && !step_has && !m_tvalid |=> !m_tvalid)
		else $error("result from empty frame");
`endif

endmodule
`default_nettype wire
